// ===== src/irfd_pkg.sv =====
// Shared types and constants for the IR remote frame decoder.
// Depends on nothing; every other file in src uses it by scoped names.
`default_nettype none

package irfd_pkg;

  localparam int unsigned LEAD_MARK_LO    = 140;
  localparam int unsigned LEAD_MARK_HI    = 141;
  localparam int unsigned DATA_SPACE_LO   = 68;
  localparam int unsigned DATA_SPACE_HI   = 72;
  localparam int unsigned REPEAT_SPACE_LO = 34;
  localparam int unsigned REPEAT_SPACE_HI = 36;
  localparam int unsigned SHORT_LO        = 7;
  localparam int unsigned SHORT_HI        = 10;
  localparam int unsigned LONG_LO         = 25;
  localparam int unsigned LONG_HI         = 27;
  localparam int unsigned MAX_RUN         = 141;

  localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd1563;
  localparam logic [15:0] RST_EXP_ADDRESS  = 16'hbf00;
  localparam logic [15:0] RST_OFF_CODE     = 16'hff00;
  localparam logic [15:0] RST_LED_CODE     = 16'hfe01;
  localparam logic [15:0] RST_BUZZER_CODE  = 16'hf609;

  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IDLE_TIMEOUT = 3'd0,
    CFG_EXP_ADDRESS  = 3'd1,
    CFG_OFF_CODE     = 3'd2,
    CFG_LED_CODE     = 3'd3,
    CFG_BUZZER_CODE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [6:0] {
    PH_IDLE          = 7'b0000001,
    PH_LEAD_SPACE    = 7'b0000010,
    PH_ADDR_MARK     = 7'b0000100,
    PH_ADDR_SPACE    = 7'b0001000,
    PH_CMD_MARK      = 7'b0010000,
    PH_CMD_SPACE_OK  = 7'b0100000,
    PH_CMD_SPACE_BAD = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [15:0] idle_timeout;
    logic [15:0] exp_address;
    logic [15:0] off_code;
    logic [15:0] led_code;
    logic [15:0] buzzer_code;
  } cfg_t;

  typedef struct packed {
    logic [15:0] code;
    logic        led_on;
    logic        buzzer_on;
    logic        by_timeout;
  } res_t;

endpackage

`default_nettype wire

// ===== src/irfd_cfg.sv =====
// Configuration register bank of the IR remote frame decoder.
// Depends on irfd_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module irfd_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [irfd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [15:0]                       cfg_data_i,
  output irfd_pkg::cfg_t                         cfg_o
);

  irfd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (irfd_pkg::cfg_idx_e'(cfg_index_i))
        irfd_pkg::CFG_IDLE_TIMEOUT: cfg_d.idle_timeout = cfg_data_i;
        irfd_pkg::CFG_EXP_ADDRESS:  cfg_d.exp_address  = cfg_data_i;
        irfd_pkg::CFG_OFF_CODE:     cfg_d.off_code     = cfg_data_i;
        irfd_pkg::CFG_LED_CODE:     cfg_d.led_code     = cfg_data_i;
        irfd_pkg::CFG_BUZZER_CODE:  cfg_d.buzzer_code  = cfg_data_i;
        default:                    cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout <= irfd_pkg::RST_IDLE_TIMEOUT;
      cfg_q.exp_address  <= irfd_pkg::RST_EXP_ADDRESS;
      cfg_q.off_code     <= irfd_pkg::RST_OFF_CODE;
      cfg_q.led_code     <= irfd_pkg::RST_LED_CODE;
      cfg_q.buzzer_code  <= irfd_pkg::RST_BUZZER_CODE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/irfd_core.sv =====
// Per-sample decoder: run-width counter, frame state machine and code state.
// Depends on irfd_pkg for the phase encoding, timing windows and bundles.
`default_nettype none

module irfd_core #(
  parameter int unsigned TickCounterBits = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic           ir_level_i,
  input  irfd_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output irfd_pkg::res_t      res_o
);

  localparam int unsigned Cw = (TickCounterBits > 16) ? TickCounterBits : 16;
  localparam logic [TickCounterBits-1:0] WidthMax = {TickCounterBits{1'b1}};
  localparam logic [TickCounterBits-1:0] WidthOne = TickCounterBits'(1);

  irfd_pkg::phase_e             phase_q, phase_d;
  logic                         prev_q;
  logic [TickCounterBits-1:0]   width_q, width_d;
  logic [4:0]                   bit_q, bit_d;
  logic [15:0]                  cmd_q, cmd_d;
  logic [15:0]                  code_q, code_d;
  logic                         led_q, led_d;
  logic                         buz_q, buz_d;
  logic                         short_run, long_run, lead_mark, data_space;
  logic                         frame_done, tmo_fire, space_bit;
  logic [4:0]                   bit_inc;
  logic [15:0]                  cmd_set;
  logic [15:0]                  new_code;

  function automatic logic in_win(input logic [TickCounterBits-1:0] v,
                                  input int unsigned lo, input int unsigned hi);
    in_win = (v >= TickCounterBits'(lo)) && (v <= TickCounterBits'(hi));
  endfunction

  always_comb begin
    short_run  = in_win(width_q, irfd_pkg::SHORT_LO, irfd_pkg::SHORT_HI);
    long_run   = in_win(width_q, irfd_pkg::LONG_LO, irfd_pkg::LONG_HI);
    lead_mark  = in_win(width_q, irfd_pkg::LEAD_MARK_LO, irfd_pkg::LEAD_MARK_HI);
    data_space = in_win(width_q, irfd_pkg::DATA_SPACE_LO, irfd_pkg::DATA_SPACE_HI);
    bit_inc    = bit_q + 5'd1;
    space_bit  = (phase_q == irfd_pkg::PH_CMD_SPACE_OK) && long_run;
    cmd_set    = cmd_q;
    cmd_set[bit_q[3:0]] = cmd_q[bit_q[3:0]] | space_bit;

    phase_d    = phase_q;
    bit_d      = bit_q;
    cmd_d      = cmd_q;
    width_d    = width_q;
    frame_done = 1'b0;

    if (ir_level_i != prev_q) begin
      width_d = WidthOne;
      if (!prev_q) begin
        case (phase_q)
          irfd_pkg::PH_IDLE: begin
            if (lead_mark) begin
              phase_d = irfd_pkg::PH_LEAD_SPACE;
            end
          end
          irfd_pkg::PH_ADDR_MARK: begin
            phase_d = short_run ? irfd_pkg::PH_ADDR_SPACE : irfd_pkg::PH_IDLE;
          end
          irfd_pkg::PH_CMD_MARK: begin
            phase_d = short_run ? irfd_pkg::PH_CMD_SPACE_OK : irfd_pkg::PH_CMD_SPACE_BAD;
          end
          default: phase_d = irfd_pkg::PH_IDLE;
        endcase
      end else begin
        case (phase_q)
          irfd_pkg::PH_IDLE: phase_d = irfd_pkg::PH_IDLE;
          irfd_pkg::PH_LEAD_SPACE: begin
            if (data_space) begin
              phase_d = irfd_pkg::PH_ADDR_MARK;
              bit_d   = 5'd0;
            end else begin
              phase_d = irfd_pkg::PH_IDLE;
            end
          end
          irfd_pkg::PH_ADDR_SPACE: begin
            if ((!short_run && !long_run) ||
                (long_run != cfg_i.exp_address[bit_q[3:0]])) begin
              phase_d = irfd_pkg::PH_IDLE;
            end else begin
              bit_d = bit_inc;
              if (bit_inc[4]) begin
                cmd_d   = 16'd0;
                phase_d = irfd_pkg::PH_CMD_MARK;
              end else begin
                phase_d = irfd_pkg::PH_ADDR_MARK;
              end
            end
          end
          irfd_pkg::PH_CMD_SPACE_OK, irfd_pkg::PH_CMD_SPACE_BAD: begin
            cmd_d = cmd_set;
            bit_d = bit_inc;
            if (bit_inc == 5'd0) begin
              phase_d    = irfd_pkg::PH_IDLE;
              frame_done = 1'b1;
            end else begin
              phase_d = irfd_pkg::PH_CMD_MARK;
            end
          end
          default: phase_d = irfd_pkg::PH_IDLE;
        endcase
      end
    end else if (width_q != WidthMax) begin
      width_d = width_q + WidthOne;
    end

    if ((phase_d != irfd_pkg::PH_IDLE) &&
        (width_d > TickCounterBits'(irfd_pkg::MAX_RUN))) begin
      phase_d = irfd_pkg::PH_IDLE;
    end

    tmo_fire = !frame_done && (phase_d == irfd_pkg::PH_IDLE) && ir_level_i &&
               (Cw'(width_d) >= Cw'(cfg_i.idle_timeout));
    if (tmo_fire) begin
      width_d = '0;
    end

    new_code = frame_done ? cmd_set : cfg_i.off_code;
    code_d   = code_q;
    led_d    = led_q;
    buz_d    = buz_q;
    if (frame_done || tmo_fire) begin
      code_d = new_code;
      if (new_code == cfg_i.off_code) begin
        led_d = 1'b0;
        buz_d = 1'b0;
      end else if (new_code == cfg_i.led_code) begin
        led_d = 1'b1;
      end else if (new_code == cfg_i.buzzer_code) begin
        buz_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= irfd_pkg::PH_IDLE;
      prev_q  <= 1'b1;
      width_q <= '0;
      bit_q   <= 5'd0;
      cmd_q   <= 16'd0;
      code_q  <= 16'd0;
      led_q   <= 1'b0;
      buz_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      prev_q  <= ir_level_i;
      width_q <= width_d;
      bit_q   <= bit_d;
      cmd_q   <= cmd_d;
      code_q  <= code_d;
      led_q   <= led_d;
      buz_q   <= buz_d;
    end
  end

  assign res_valid_o      = accept_i && (frame_done || tmo_fire);
  assign res_o.code       = code_d;
  assign res_o.led_on     = led_d;
  assign res_o.buzzer_on  = buz_d;
  assign res_o.by_timeout = tmo_fire;

endmodule

`default_nettype wire

// ===== src/irfd_outreg.sv =====
// Result register of the IR remote frame decoder with its output handshake.
// Depends on irfd_pkg for the res_t bundle.
`default_nettype none

module irfd_outreg (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  irfd_pkg::res_t res_i,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output logic           full_stall_o,
  output irfd_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  irfd_pkg::res_t res_q;

  assign full_stall_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== src/ir_remote_frame_decoder.sv =====
// Top level of the IR remote frame decoder: config bank, decoder and result register.
// Depends on irfd_pkg, irfd_cfg, irfd_core and irfd_outreg.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_stall_o    ir_level_i
//   out       output     out_valid_o / out_stall_i  code_o, led_on_o, buzzer_on_o, by_timeout_o
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One line sample is taken every clock cycle unless the input is stalled; its
// result, if any, is in the result register in the cycle after the sample beat.
// The decoder state updates in the same edge as the accepted beat.
// Input is stalled only while a result waits and the output side stalls.
// Reset clears the decoder state and loads the default register values.
`default_nettype none

module ir_remote_frame_decoder #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              ir_level_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [15:0]                            code_o,
  output logic                                   led_on_o,
  output logic                                   buzzer_on_o,
  output logic                                   by_timeout_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [irfd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [15:0]                       cfg_data_i
);

  irfd_pkg::cfg_t cfg;
  irfd_pkg::res_t core_res;
  irfd_pkg::res_t out_res;
  logic           in_accept;
  logic           res_valid;

  assign in_accept = in_valid_i && !in_stall_o;

  irfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  irfd_core #(
    .TickCounterBits (TICK_COUNTER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .ir_level_i  (ir_level_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  irfd_outreg u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_valid),
    .res_i        (core_res),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .full_stall_o (in_stall_o),
    .res_o        (out_res)
  );

  assign code_o       = out_res.code;
  assign led_on_o     = out_res.led_on;
  assign buzzer_on_o  = out_res.buzzer_on;
  assign by_timeout_o = out_res.by_timeout;

`ifndef SYNTH
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled without a pending result.");

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && by_timeout_o) |-> (!led_on_o && !buzzer_on_o))
    else $error("Timeout result left LED or buzzer on.");

  a_result_from_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("Result appeared without an accepted sample.");
`endif

endmodule

`default_nettype wire
